[rtl/core/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// gcd_pkg
// shared constants and arctangent table for the great-circle distance core
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int LatW = 31;
  localparam int LonW = 32;
  localparam int OutW = 31;

  localparam int CordW = 44; // q40 cordic datapath, signed
  localparam int AngW  = 34; // q30 angle, signed

  localparam logic signed [LatW-1:0] LatLimit   = 31'sd900000000;
  localparam logic signed [35:0]     HalfTurn   = 36'sd1800000000;
  localparam logic signed [35:0]     FullTurn   = 36'sd3600000000;
  localparam logic signed [35:0]     QuarterTurn = 36'sd900000000;
  localparam logic [33:0]            DegToRad   = 34'd8048910509;
  localparam logic signed [CordW-1:0] GainQ40   = 44'sd667681663043;
  localparam logic signed [AngW-1:0] HalfPiQ30  = 34'sd1686629713;
  localparam logic [29:0]            RadiusCm   = 30'd637813700;
  localparam logic [OutW-1:0]        MaxCm      = 31'd2003750835;

  function automatic logic signed [AngW-1:0] atan_q30(input int i);
    logic signed [AngW-1:0] r;
    r = '0;
    unique case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: begin
        if (i <= 30) r = AngW'(64'sd1 <<< (30 - i));
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/great_circle_distance_core.sv]
// ----------------------------------------------------------------------------
// great_circle_distance_core
// pipelined fixed-point haversine distance between two lat/lon points
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid_i / in_stall_o with four coordinate fields in
//   degrees * 1e7. output channel: out_valid_o / out_stall_i with the
//   distance in centimetres. a transaction moves when valid is high and
//   stall is low.
//   one point pair is taken every cycle while the pipeline is not stalled.
//   the pipeline consists of three front stages, sin/cos cordic, one
//   rounding stage, three multiply/sum stages, bit-serial square roots of
//   32 stages, one rounding stage, vectoring cordic and two scaling
//   stages; the rotation and vectoring cordic and the root units are one
//   stage each per step.
//   stall from the receiver freezes the whole pipeline at once; in_stall_o
//   follows out_stall_i only when the last stage holds a result, and
//   bubbles inside the pipe are kept. reset clears all valid bits; data
//   registers are not reset.
// ----------------------------------------------------------------------------
module great_circle_distance_core #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [30:0]       first_lat_i,
  input  logic signed [31:0]       first_lon_i,
  input  logic signed [30:0]       second_lat_i,
  input  logic signed [31:0]       second_lon_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [30:0]              distance_cm_o
);

  localparam int CW = gcd_pkg::CordW;
  localparam int AW = gcd_pkg::AngW;
  localparam int NS = CORDIC_STAGES;
  localparam int SQ = 32;
  // stage count: 3 front + NS rot + 1 round + 3 mul/sum + SQ root + 1 pre
  // + NS vec + 2 scale
  localparam int TOTAL = 3 + NS + 1 + 3 + SQ + 1 + NS + 2;

  logic adv;
  logic [TOTAL-1:0] vld_q;

  // stall the whole pipe only when a result waits at the output
  assign adv = !(vld_q[TOTAL-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOTAL-2:0], in_valid_i};
    end
  end

  // ---------------- front: clamp, difference, reduce ----------------
  logic signed [30:0] lat1_q, lat2_q;
  logic signed [35:0] dl_q;

  function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
    if (v > gcd_pkg::LatLimit) return gcd_pkg::LatLimit;
    if (v < -gcd_pkg::LatLimit) return -gcd_pkg::LatLimit;
    return v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lat1_q <= clamp_lat(first_lat_i);
      lat2_q <= clamp_lat(second_lat_i);
      dl_q   <= 36'(first_lon_i) - 36'(second_lon_i);
    end
  end

  // difference lies in (-2*full, 2*full); modulo keeps sign of dividend
  logic signed [35:0] dl_m, dl_r;
  logic flip_d;
  always_comb begin
    dl_m = dl_q;
    if (dl_m >= gcd_pkg::FullTurn) dl_m = dl_m - gcd_pkg::FullTurn;
    else if (dl_m <= -gcd_pkg::FullTurn) dl_m = dl_m + gcd_pkg::FullTurn;
    if (dl_m > gcd_pkg::HalfTurn) dl_m = dl_m - gcd_pkg::FullTurn;
    if (dl_m <= -gcd_pkg::HalfTurn) dl_m = dl_m + gcd_pkg::FullTurn;
    flip_d = 1'b0;
    dl_r = dl_m;
    if (dl_m > gcd_pkg::QuarterTurn) begin
      dl_r = dl_m - gcd_pkg::HalfTurn;
      flip_d = 1'b1;
    end else if (dl_m < -gcd_pkg::QuarterTurn) begin
      dl_r = dl_m + gcd_pkg::HalfTurn;
      flip_d = 1'b1;
    end
  end

  // magnitude and sign registered here; to_rad forms the product and rounds it
  logic [29:0] m1_q, m2_q, m3_q;
  logic n1_q, n2_q, n3_q, flip1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q <= lat1_q[30];
      m1_q <= lat1_q[30] ? 30'(-lat1_q) : 30'(lat1_q);
      n2_q <= lat2_q[30];
      m2_q <= lat2_q[30] ? 30'(-lat2_q) : 30'(lat2_q);
      n3_q <= dl_r[35];
      m3_q <= dl_r[35] ? 30'(-dl_r) : 30'(dl_r);
      flip1_q <= flip_d;
    end
  end

  function automatic logic signed [AW-1:0] to_rad(input logic [29:0] m, input logic n);
    logic [63:0] p;
    logic [31:0] r;
    p = 64'(m) * 64'(gcd_pkg::DegToRad) + 64'h8000_0000;
    r = p[63:32];
    return n ? -AW'(signed'({1'b0, r})) : AW'(signed'({1'b0, r}));
  endfunction

  // ---------------- rotation cordic, three lanes ----------------
  logic signed [CW-1:0] rx_q [NS+1][3];
  logic signed [CW-1:0] ry_q [NS+1][3];
  logic signed [AW-1:0] rz_q [NS+1][3];
  logic                 rf_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rz_q[0][0] <= to_rad(m1_q, n1_q);
      rz_q[0][1] <= to_rad(m2_q, n2_q);
      rz_q[0][2] <= to_rad(m3_q, n3_q);
      rf_q[0]    <= flip1_q;
      for (int l = 0; l < 3; l++) begin
        rx_q[0][l] <= gcd_pkg::GainQ40;
        ry_q[0][l] <= '0;
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rf_q[s+1] <= rf_q[s];
        for (int l = 0; l < 3; l++) begin
          if (!rz_q[s][l][AW-1]) begin
            rx_q[s+1][l] <= rx_q[s][l] - (ry_q[s][l] >>> s);
            ry_q[s+1][l] <= ry_q[s][l] + (rx_q[s][l] >>> s);
            rz_q[s+1][l] <= rz_q[s][l] - gcd_pkg::atan_q30(s);
          end else begin
            rx_q[s+1][l] <= rx_q[s][l] + (ry_q[s][l] >>> s);
            ry_q[s+1][l] <= ry_q[s][l] - (rx_q[s][l] >>> s);
            rz_q[s+1][l] <= rz_q[s][l] + gcd_pkg::atan_q30(s);
          end
        end
      end
    end
  end

  // round to q30 and apply the half-turn fold
  function automatic logic signed [33:0] rnd_q30(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + CW'(512)) >>> 10;
    return 34'(t);
  endfunction

  logic signed [33:0] s1_q, c1_q, s2_q, c2_q, sd_q, cd_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= rnd_q30(rx_q[NS][0]);
      s1_q <= rnd_q30(ry_q[NS][0]);
      c2_q <= rnd_q30(rx_q[NS][1]);
      s2_q <= rnd_q30(ry_q[NS][1]);
      cd_q <= rf_q[NS] ? -rnd_q30(rx_q[NS][2]) : rnd_q30(rx_q[NS][2]);
      sd_q <= rf_q[NS] ? -rnd_q30(ry_q[NS][2]) : rnd_q30(ry_q[NS][2]);
    end
  end

  // ---------------- chord vector ----------------
  logic signed [67:0] pcx_q, pcy_q;
  logic signed [33:0] c2b_q, dz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pcx_q <= 68'(cd_q) * 68'(c1_q);
      pcy_q <= 68'(sd_q) * 68'(c1_q);
      c2b_q <= c2_q;
      dz_q  <= s1_q - s2_q;
    end
  end

  function automatic logic signed [33:0] rnd_p30(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = (p + 68'sd536870912) >>> 30;
    return 34'(t);
  endfunction

  logic signed [33:0] dx_q, dy_q, dz2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q  <= rnd_p30(pcx_q) - c2b_q;
      dy_q  <= rnd_p30(pcy_q);
      dz2_q <= dz_q;
    end
  end

  function automatic logic [63:0] sq(input logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    return 64'(m) * 64'(m);
  endfunction

  logic [63:0] sum_d;
  logic [63:0] rq_v [SQ+1];
  logic [63:0] rq_r [SQ+1];
  logic [63:0] rc_v [SQ+1];
  logic [63:0] rc_r [SQ+1];
  localparam logic [63:0] Lim = 64'd1 << 62;

  always_comb begin
    sum_d = sq(dx_q) + sq(dy_q) + sq(dz2_q);
    if (sum_d > Lim) sum_d = Lim;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rq_v[0] <= sum_d;
      rc_v[0] <= Lim - sum_d;
      rq_r[0] <= '0;
      rc_r[0] <= '0;
    end
  end

  // ---------------- bit-serial square roots, one bit per stage ----------
  for (genvar s = 0; s < SQ; s++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * s);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rq_v[s] >= rq_r[s] + Bit) begin
          rq_v[s+1] <= rq_v[s] - (rq_r[s] + Bit);
          rq_r[s+1] <= (rq_r[s] >> 1) + Bit;
        end else begin
          rq_v[s+1] <= rq_v[s];
          rq_r[s+1] <= rq_r[s] >> 1;
        end
        if (rc_v[s] >= rc_r[s] + Bit) begin
          rc_v[s+1] <= rc_v[s] - (rc_r[s] + Bit);
          rc_r[s+1] <= (rc_r[s] >> 1) + Bit;
        end else begin
          rc_v[s+1] <= rc_v[s];
          rc_r[s+1] <= rc_r[s] >> 1;
        end
      end
    end
  end

  // rounding of both roots and start of vectoring cordic
  logic [32:0] qv, cv;
  always_comb begin
    qv = 33'(rq_r[SQ]) + ((rq_v[SQ] > rq_r[SQ]) ? 33'd1 : 33'd0);
    cv = 33'(rc_r[SQ]) + ((rc_v[SQ] > rc_r[SQ]) ? 33'd1 : 33'd0);
  end

  logic signed [CW-1:0] vx_q [NS+1];
  logic signed [CW-1:0] vy_q [NS+1];
  logic signed [AW-1:0] vz_q [NS+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx_q[0] <= CW'({cv, 10'd0});
      vy_q[0] <= CW'({qv, 10'd0});
      vz_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!vy_q[s][CW-1]) begin
          vx_q[s+1] <= vx_q[s] + (vy_q[s] >>> s);
          vy_q[s+1] <= vy_q[s] - (vx_q[s] >>> s);
          vz_q[s+1] <= vz_q[s] + gcd_pkg::atan_q30(s);
        end else begin
          vx_q[s+1] <= vx_q[s] - (vy_q[s] >>> s);
          vy_q[s+1] <= vy_q[s] + (vx_q[s] >>> s);
          vz_q[s+1] <= vz_q[s] - gcd_pkg::atan_q30(s);
        end
      end
    end
  end

  // ---------------- clamp angle, scale to centimetres ----------------
  logic [30:0] th;
  always_comb begin
    if (vz_q[NS][AW-1]) th = '0;
    else if (vz_q[NS] > gcd_pkg::HalfPiQ30) th = 31'(gcd_pkg::HalfPiQ30);
    else th = 31'(vz_q[NS]);
  end

  logic [61:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (adv) prod_q <= 62'(th) * 62'(gcd_pkg::RadiusCm);
  end

  logic [62:0] cm_w;
  logic [32:0] cm_v;
  logic [30:0] dist_q;
  always_comb begin
    cm_w = {prod_q, 1'b0} + 63'd536870912;
    cm_v = cm_w[62:30];
  end
  always_ff @(posedge clk_i) begin
    if (adv) dist_q <= (cm_v > 33'(gcd_pkg::MaxCm)) ? gcd_pkg::MaxCm : cm_v[30:0];
  end

  assign out_valid_o   = vld_q[TOTAL-1];
  assign distance_cm_o = dist_q;

  // ---------------- assertions ----------------
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_cm_o <= gcd_pkg::MaxCm) else $error("distance out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_cm_o))
    else $error("held result changed");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i) else $error("spurious input stall");

endmodule
